>>> sv/pcik_pkg.sv
`default_nettype none
package pcik_pkg;

    localparam int unsigned MAX_BONES = 5;
    localparam int unsigned IDX_W = 3;
    localparam int unsigned POS_W = 28;      // internal position, Q.16
    localparam int unsigned VEC_W = 29;      // differences of positions
    localparam int unsigned MUL_W = 33;      // shared multiplier operand width
    localparam int unsigned TRIG_W = 33;     // CORDIC x/y, Q2.30
    localparam int unsigned ZACC_W = 26;     // CORDIC angle, 2^24 per turn

    localparam logic signed [TRIG_W-1:0] CORDIC_K30 = 33'sd652032874;
    localparam logic [31:0] RAD_TO_BAM_Q8 = 32'd2670177;

    // register map, word index
    localparam logic [2:0] REG_LEN_A = 3'd0;
    localparam logic [2:0] REG_LEN_B = 3'd1;
    localparam logic [2:0] REG_LEN_C = 3'd2;
    localparam logic [2:0] REG_LEN_D = 3'd3;
    localparam logic [2:0] REG_LEN_E = 3'd4;
    localparam logic [2:0] REG_GAIN  = 3'd5;
    localparam logic [2:0] REG_STOP  = 3'd6;

    localparam logic [15:0] LEN_A_RST = 16'd1792;
    localparam logic [15:0] LEN_B_RST = 16'd3456;
    localparam logic [15:0] LEN_C_RST = 16'd2816;
    localparam logic [15:0] LEN_D_RST = 16'd896;
    localparam logic [15:0] LEN_E_RST = 16'd1024;
    localparam logic [23:0] GAIN_RST  = 24'd168;
    localparam logic [15:0] STOP_RST  = 16'd1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FK_START,
        ST_FK_WAIT,
        ST_FK_MC,
        ST_FK_MS,
        ST_FK_AS,
        ST_D_SUB,
        ST_D_M1,
        ST_D_M2,
        ST_D_M3,
        ST_D_CMP,
        ST_U_M1,
        ST_U_M2,
        ST_U_DOT,
        ST_U_G1,
        ST_U_G2,
        ST_U_G3,
        ST_U_K1,
        ST_U_K2,
        ST_U_K3,
        ST_DONE
    } state_t;

    // atan(2^-i) in 2^24-per-turn units
    function automatic logic [ZACC_W-1:0] atan_lut(input logic [3:0] i);
        logic [ZACC_W-1:0] v;
        unique case (i)
            4'd0:  v = 26'd2097152;
            4'd1:  v = 26'd1238021;
            4'd2:  v = 26'd654136;
            4'd3:  v = 26'd332050;
            4'd4:  v = 26'd166669;
            4'd5:  v = 26'd83416;
            4'd6:  v = 26'd41718;
            4'd7:  v = 26'd20860;
            4'd8:  v = 26'd10430;
            4'd9:  v = 26'd5215;
            4'd10: v = 26'd2608;
            4'd11: v = 26'd1304;
            4'd12: v = 26'd652;
            4'd13: v = 26'd326;
            4'd14: v = 26'd163;
            default: v = 26'd81;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> sv/planar_chain_ik_step_top.sv
`default_nettype none
// Channel   | Dir | Beat contents
// s_ (in)   | in  | tdata: target_x[24:0], target_y[49:25], zero pad to 56
// m_ (out)  | out | tdata: effector_x, effector_y, angle_a..angle_e (136); tuser: converged
// APB cfg   | in  | regs 0..6 at byte addr 4*i: lengths a..e, gain, stop distance
//
// One beat at a time: for each bone, forward kinematics starts the CORDIC, waits on
// its loop and runs three multiply/accumulate steps; then comes the distance test,
// then the update of each bone, which is skipped when the stop test passes. The
// CORDIC unit and the single shared multiplier set the pace. s_tready is high only
// in idle; a finished result sits in the output register while the next beat is
// taken, and a result still waiting there holds the block in its last state. Reset
// (aresetn, synchronous) zeroes the angles and loads the register defaults.
module planar_chain_ik_step_top #(
    parameter int unsigned NUM_BONES = 5
) (
    input  wire          aclk,
    input  wire          aresetn,
    // input stream
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [55:0]  s_tdata,   // target_x[24:0], target_y[49:25], pad
    // result stream
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [135:0] m_tdata,   // effector_x, effector_y, angle_a..e, pad
    output logic         m_tuser,   // converged
    // configuration
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int unsigned PW = pcik_pkg::POS_W;
    localparam int unsigned VW = pcik_pkg::VEC_W;
    localparam int unsigned MW = pcik_pkg::MUL_W;
    localparam logic [pcik_pkg::IDX_W-1:0] LAST_BONE = pcik_pkg::IDX_W'(NUM_BONES - 1);

    pcik_pkg::state_t state_reg, state_next;

    logic [15:0]    len_reg [pcik_pkg::MAX_BONES];
    logic [23:0]    gain_reg;
    logic [15:0]    stop_reg;
    logic [15:0]    ang_reg [pcik_pkg::MAX_BONES];

    logic [pcik_pkg::IDX_W-1:0] idx_reg;
    logic [15:0]                phi_reg;
    logic signed [24:0]         tx_reg, ty_reg;
    logic signed [PW-1:0]       px_reg, py_reg;
    logic signed [PW-1:0]       bx_reg [pcik_pkg::MAX_BONES];
    logic signed [PW-1:0]       by_reg [pcik_pkg::MAX_BONES];
    logic signed [VW-1:0]       vx_reg, vy_reg;
    logic [63:0]                acc_reg, tmp_reg;
    logic                       conv_reg;

    logic                       m_tvalid_reg;
    logic [135:0]               m_tdata_reg;
    logic                       m_tuser_reg;

    // datapath helpers
    logic [15:0]                phi_sum;
    logic                       cor_start, cor_done;
    logic signed [pcik_pkg::TRIG_W-1:0] cos_w, sin_w;
    logic signed [MW-1:0]       mul_a, mul_b;
    logic signed [2*MW-1:0]     prod;
    logic signed [49:0]         rnd;
    logic signed [VW-1:0]       rx, ry;
    logic signed [63:0]         dot;
    logic [63:0]                p_full, p_bias;
    logic                       out_free, cfg_wr;

    function automatic logic [24:0] sat25(input logic signed [PW-1:0] v);
        logic [24:0] r;
        if (v > $signed(PW'(25'h0FFFFFF)))
            r = 25'h0FFFFFF;
        else if (v < -$signed(PW'(26'h1000000)))
            r = 25'h1000000;
        else
            r = v[24:0];
        return r;
    endfunction

    pcik_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (phi_sum),
        .done    (cor_done),
        .cos_o   (cos_w),
        .sin_o   (sin_w)
    );

    pcik_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign phi_sum  = phi_reg + ang_reg[idx_reg];
    assign rnd      = $signed(prod[49:0]) + 50'sd2097152;   // round half up at bit 22
    assign rx       = {px_reg[PW-1], px_reg} - {bx_reg[idx_reg][PW-1], bx_reg[idx_reg]};
    assign ry       = {py_reg[PW-1], py_reg} - {by_reg[idx_reg][PW-1], by_reg[idx_reg]};
    assign dot      = $signed(acc_reg) - $signed(prod[63:0]);
    assign p_full   = tmp_reg + {prod[31:0], 32'b0};
    assign p_bias   = p_full + 64'h0000_8000_0000_0000;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pcik_pkg::ST_IDLE:     if (s_tvalid) state_next = pcik_pkg::ST_FK_START;
            pcik_pkg::ST_FK_START: state_next = pcik_pkg::ST_FK_WAIT;
            pcik_pkg::ST_FK_WAIT:  if (cor_done) state_next = pcik_pkg::ST_FK_MC;
            pcik_pkg::ST_FK_MC:    state_next = pcik_pkg::ST_FK_MS;
            pcik_pkg::ST_FK_MS:    state_next = pcik_pkg::ST_FK_AS;
            pcik_pkg::ST_FK_AS:    state_next = (idx_reg == LAST_BONE) ?
                                       pcik_pkg::ST_D_SUB : pcik_pkg::ST_FK_START;
            pcik_pkg::ST_D_SUB:    state_next = pcik_pkg::ST_D_M1;
            pcik_pkg::ST_D_M1:     state_next = pcik_pkg::ST_D_M2;
            pcik_pkg::ST_D_M2:     state_next = pcik_pkg::ST_D_M3;
            pcik_pkg::ST_D_M3:     state_next = pcik_pkg::ST_D_CMP;
            pcik_pkg::ST_D_CMP:    state_next = (acc_reg > {2'b0, prod[61:0]}) ?
                                       pcik_pkg::ST_U_M1 : pcik_pkg::ST_DONE;
            pcik_pkg::ST_U_M1:     state_next = pcik_pkg::ST_U_M2;
            pcik_pkg::ST_U_M2:     state_next = pcik_pkg::ST_U_DOT;
            pcik_pkg::ST_U_DOT:    state_next = pcik_pkg::ST_U_G1;
            pcik_pkg::ST_U_G1:     state_next = pcik_pkg::ST_U_G2;
            pcik_pkg::ST_U_G2:     state_next = pcik_pkg::ST_U_G3;
            pcik_pkg::ST_U_G3:     state_next = pcik_pkg::ST_U_K1;
            pcik_pkg::ST_U_K1:     state_next = pcik_pkg::ST_U_K2;
            pcik_pkg::ST_U_K2:     state_next = pcik_pkg::ST_U_K3;
            pcik_pkg::ST_U_K3:     state_next = (idx_reg == LAST_BONE) ?
                                       pcik_pkg::ST_DONE : pcik_pkg::ST_U_M1;
            pcik_pkg::ST_DONE:     if (out_free) state_next = pcik_pkg::ST_IDLE;
            default:               state_next = pcik_pkg::ST_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    always_comb begin
        s_tready  = 1'b0;
        cor_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            pcik_pkg::ST_IDLE:     s_tready = 1'b1;
            pcik_pkg::ST_FK_START: cor_start = 1'b1;
            pcik_pkg::ST_FK_MC: begin
                mul_a = {17'b0, len_reg[idx_reg]};
                mul_b = cos_w;
            end
            pcik_pkg::ST_FK_MS: begin
                mul_a = {17'b0, len_reg[idx_reg]};
                mul_b = sin_w;
            end
            pcik_pkg::ST_D_M1: begin
                mul_a = MW'(vx_reg);
                mul_b = MW'(vx_reg);
            end
            pcik_pkg::ST_D_M2: begin
                mul_a = MW'(vy_reg);
                mul_b = MW'(vy_reg);
            end
            pcik_pkg::ST_D_M3: begin
                mul_a = {17'b0, stop_reg};
                mul_b = {17'b0, stop_reg};
            end
            pcik_pkg::ST_U_M1: begin
                mul_a = MW'(rx);
                mul_b = MW'(vy_reg);
            end
            pcik_pkg::ST_U_M2: begin
                mul_a = MW'(ry);
                mul_b = MW'(vx_reg);
            end
            pcik_pkg::ST_U_G1: begin
                mul_a = {1'b0, acc_reg[31:0]};
                mul_b = {9'b0, gain_reg};
            end
            pcik_pkg::ST_U_G2: begin
                mul_a = {acc_reg[63], acc_reg[63:32]};
                mul_b = {9'b0, gain_reg};
            end
            pcik_pkg::ST_U_K1: begin
                mul_a = {1'b0, acc_reg[31:0]};
                mul_b = {1'b0, pcik_pkg::RAD_TO_BAM_Q8};
            end
            pcik_pkg::ST_U_K2: begin
                mul_a = {acc_reg[63], acc_reg[63:32]};
                mul_b = {1'b0, pcik_pkg::RAD_TO_BAM_Q8};
            end
            default: ;
        endcase
    end

    // control state, angles and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pcik_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            len_reg[0]   <= pcik_pkg::LEN_A_RST;
            len_reg[1]   <= pcik_pkg::LEN_B_RST;
            len_reg[2]   <= pcik_pkg::LEN_C_RST;
            len_reg[3]   <= pcik_pkg::LEN_D_RST;
            len_reg[4]   <= pcik_pkg::LEN_E_RST;
            gain_reg     <= pcik_pkg::GAIN_RST;
            stop_reg     <= pcik_pkg::STOP_RST;
            for (int i = 0; i < pcik_pkg::MAX_BONES; i++)
                ang_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            // a new result loads in the same cycle the old one leaves
            if ((state_reg == pcik_pkg::ST_DONE && out_free) || (m_tvalid_reg && m_tready))
                m_tvalid_reg <= (state_reg == pcik_pkg::ST_DONE);
            if (state_reg == pcik_pkg::ST_U_K3)
                ang_reg[idx_reg] <= ang_reg[idx_reg] + p_bias[63:48];
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    pcik_pkg::REG_LEN_A: len_reg[0] <= pwdata[15:0];
                    pcik_pkg::REG_LEN_B: len_reg[1] <= pwdata[15:0];
                    pcik_pkg::REG_LEN_C: len_reg[2] <= pwdata[15:0];
                    pcik_pkg::REG_LEN_D: len_reg[3] <= pwdata[15:0];
                    pcik_pkg::REG_LEN_E: len_reg[4] <= pwdata[15:0];
                    pcik_pkg::REG_GAIN:  gain_reg   <= pwdata[23:0];
                    pcik_pkg::REG_STOP:  stop_reg   <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            pcik_pkg::ST_IDLE: begin
                tx_reg  <= $signed(s_tdata[24:0]);
                ty_reg  <= $signed(s_tdata[49:25]);
                px_reg  <= '0;
                py_reg  <= '0;
                phi_reg <= '0;
                idx_reg <= '0;
            end
            pcik_pkg::ST_FK_START: begin
                phi_reg          <= phi_sum;
                bx_reg[idx_reg]  <= px_reg;
                by_reg[idx_reg]  <= py_reg;
            end
            pcik_pkg::ST_FK_MS: px_reg <= px_reg + rnd[49:22];
            pcik_pkg::ST_FK_AS: begin
                py_reg  <= py_reg + rnd[49:22];
                idx_reg <= (idx_reg == LAST_BONE) ? '0 : idx_reg + 1'b1;
            end
            pcik_pkg::ST_D_SUB: begin
                vx_reg <= {tx_reg[24], tx_reg[24], tx_reg[24], tx_reg[24], tx_reg}
                          - {px_reg[PW-1], px_reg};
                vy_reg <= {ty_reg[24], ty_reg[24], ty_reg[24], ty_reg[24], ty_reg}
                          - {py_reg[PW-1], py_reg};
            end
            pcik_pkg::ST_D_M2: acc_reg <= prod[63:0];
            pcik_pkg::ST_D_M3: acc_reg <= acc_reg + prod[63:0];
            pcik_pkg::ST_D_CMP: begin
                conv_reg <= !(acc_reg > {2'b0, prod[61:0]});
                idx_reg  <= '0;
            end
            pcik_pkg::ST_U_M2: acc_reg <= prod[63:0];
            pcik_pkg::ST_U_DOT: acc_reg <= {{16{dot[63]}}, dot[63:16]};  // floor to Q.16
            pcik_pkg::ST_U_G2: tmp_reg <= prod[63:0];
            pcik_pkg::ST_U_G3: acc_reg <= p_full;
            pcik_pkg::ST_U_K2: tmp_reg <= prod[63:0];
            pcik_pkg::ST_U_K3: idx_reg <= (idx_reg == LAST_BONE) ? '0 : idx_reg + 1'b1;
            pcik_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {6'b0, ang_reg[4], ang_reg[3], ang_reg[2], ang_reg[1],
                                    ang_reg[0], sat25(py_reg), sat25(px_reg)};
                    m_tuser_reg <= conv_reg;
                end
            end
            default: ;
        endcase
    end

    // register read-back
    always_comb begin
        unique case (paddr[4:2])
            pcik_pkg::REG_LEN_A: prdata = {16'b0, len_reg[0]};
            pcik_pkg::REG_LEN_B: prdata = {16'b0, len_reg[1]};
            pcik_pkg::REG_LEN_C: prdata = {16'b0, len_reg[2]};
            pcik_pkg::REG_LEN_D: prdata = {16'b0, len_reg[3]};
            pcik_pkg::REG_LEN_E: prdata = {16'b0, len_reg[4]};
            pcik_pkg::REG_GAIN:  prdata = {8'b0, gain_reg};
            pcik_pkg::REG_STOP:  prdata = {16'b0, stop_reg};
            default:             prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
endmodule
`default_nettype wire

>>> sv/pcik_mul.sv
`default_nettype none
// signed multiplier, product registered
module pcik_mul (
    input  wire                                      aclk,
    input  wire logic signed [pcik_pkg::MUL_W-1:0]   a,
    input  wire logic signed [pcik_pkg::MUL_W-1:0]   b,
    output logic signed [2*pcik_pkg::MUL_W-1:0]      prod
);
    logic signed [2*pcik_pkg::MUL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

>>> sv/pcik_cordic.sv
`default_nettype none
// iterative CORDIC, one micro-rotation per cycle
module pcik_cordic (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     start,
    input  wire logic [15:0]                        angle,
    output logic                                    done,
    output logic signed [pcik_pkg::TRIG_W-1:0]      cos_o,
    output logic signed [pcik_pkg::TRIG_W-1:0]      sin_o
);
    logic                                   busy_reg, busy_next;
    logic                                   done_reg, done_next;
    logic [3:0]                             cnt_reg, cnt_next;
    logic [1:0]                             quad_reg, quad_next;
    logic signed [pcik_pkg::TRIG_W-1:0]     x_reg, x_next, y_reg, y_next;
    logic signed [pcik_pkg::ZACC_W-1:0]     z_reg, z_next;
    logic signed [pcik_pkg::TRIG_W-1:0]     xs, ys;
    logic [15:0]                            biased, resid;
    logic [1:0]                             q;
    logic signed [pcik_pkg::ZACC_W-1:0]     at;

    always_comb begin
        biased = angle + 16'h2000;
        q = biased[15:14];
        resid = angle - {q, 14'b0};
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = $signed(pcik_pkg::atan_lut(cnt_reg));
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quad_next = quad_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = 4'd0;
            quad_next = q;
            x_next = pcik_pkg::CORDIC_K30;
            y_next = '0;
            z_next = {{2{resid[15]}}, resid, 8'b0};
        end else if (busy_reg) begin
            if (!z_reg[pcik_pkg::ZACC_W-1]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // quadrant restore
    always_comb begin
        unique case (quad_reg)
            2'd0: begin cos_o = x_reg;  sin_o = y_reg;  end
            2'd1: begin cos_o = -y_reg; sin_o = x_reg;  end
            2'd2: begin cos_o = -x_reg; sin_o = -y_reg; end
            default: begin cos_o = y_reg; sin_o = -x_reg; end
        endcase
    end

    assign done = done_reg;
endmodule
`default_nettype wire
